[sv/hcidfr_pkg.sv]
// shared types and codes for the spi hci event deframer
`default_nettype none
package hcidfr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE,
    PH_HDR,
    PH_ARGS,
    PH_PAD,
    PH_DRAIN
  } phase_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_REPLY  = 2'd1;
  localparam logic [1:0] ST_NO_MSG    = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  localparam logic [1:0] REG_REPLY_CODE = 2'd0;
  localparam logic [1:0] REG_EVENT_TYPE = 2'd1;
  localparam logic [1:0] REG_DATA_TYPE  = 2'd2;
  localparam logic [1:0] REG_MAX_LEN    = 2'd3;

  typedef struct packed {
    logic [7:0] reply_code;
    logic [7:0] event_type;
    logic [7:0] data_type;
    logic [7:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [1:0]  status;
    logic [15:0] opcode;
    logic [7:0]  length;
  } res_t;

endpackage
`default_nettype wire

[sv/hcidfr_parse.sv]
// frame parser: per-beat state machine and result decode
`default_nettype none
module hcidfr_parse (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_fire,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               frame_start,
  input  wire hcidfr_pkg::cfg_t   cfg,
  output hcidfr_pkg::res_t        res
);

  hcidfr_pkg::phase_t phase, phase_next;
  logic [15:0] remaining, remaining_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [7:0]  packet_type, packet_type_next;
  logic [15:0] opcode_reg, opcode_reg_next;
  logic [7:0]  length_reg, length_reg_next;
  logic [1:0]  status_reg, status_reg_next;

  logic [15:0] rem_pre;
  logic [15:0] rem_m4;
  logic [15:0] rem_m1;
  logic        hdr_ok;

  assign rem_pre = (byte_index == 2'd2) ? {rx_byte, 8'h00}
                 : (byte_index == 2'd3) ? {remaining[15:8], rx_byte}
                 : remaining;
  assign rem_m4  = remaining - 16'd4;
  assign rem_m1  = remaining - 16'd1;
  assign hdr_ok  = ((packet_type == cfg.event_type) || (packet_type == cfg.data_type))
                   && (rx_byte <= cfg.max_len);

  // next state
  always_comb begin
    phase_next       = phase;
    remaining_next   = remaining;
    byte_index_next  = byte_index;
    packet_type_next = packet_type;
    opcode_reg_next  = opcode_reg;
    length_reg_next  = length_reg;
    status_reg_next  = status_reg;
    if (frame_start) begin
      byte_index_next  = 2'd0;
      remaining_next   = 16'd0;
      packet_type_next = 8'd0;
      opcode_reg_next  = 16'd0;
      length_reg_next  = 8'd0;
      status_reg_next  = hcidfr_pkg::ST_OK;
      if (rx_byte != cfg.reply_code) begin
        status_reg_next = hcidfr_pkg::ST_NO_REPLY;
        phase_next      = hcidfr_pkg::PH_IDLE;
      end else begin
        phase_next = hcidfr_pkg::PH_PRE;
      end
    end else begin
      case (phase)
        hcidfr_pkg::PH_IDLE: begin
        end
        hcidfr_pkg::PH_PRE: begin
          remaining_next  = rem_pre;
          byte_index_next = byte_index + 2'd1;
          if (byte_index == 2'd3) begin
            if (rem_pre < 16'd4) begin
              status_reg_next = hcidfr_pkg::ST_NO_MSG;
              phase_next = (rem_pre == 16'd0) ? hcidfr_pkg::PH_IDLE : hcidfr_pkg::PH_DRAIN;
            end else begin
              phase_next = hcidfr_pkg::PH_HDR;
            end
          end
        end
        hcidfr_pkg::PH_HDR: begin
          byte_index_next = byte_index + 2'd1;
          case (byte_index)
            2'd0:    packet_type_next = rx_byte;
            2'd1:    opcode_reg_next  = {8'h00, rx_byte};
            2'd2:    opcode_reg_next  = {rx_byte, opcode_reg[7:0]};
            default: begin
              if (hdr_ok) begin
                length_reg_next = rx_byte;
                remaining_next  = {8'h00, rx_byte};
                phase_next = (rx_byte == 8'd0) ? hcidfr_pkg::PH_PAD : hcidfr_pkg::PH_ARGS;
              end else begin
                remaining_next  = rem_m4;
                status_reg_next = hcidfr_pkg::ST_INVALID;
                phase_next = (rem_m4 == 16'd0) ? hcidfr_pkg::PH_IDLE : hcidfr_pkg::PH_DRAIN;
              end
            end
          endcase
        end
        hcidfr_pkg::PH_ARGS: begin
          remaining_next = rem_m1;
          if (rem_m1 == 16'd0) begin
            phase_next = length_reg[0] ? hcidfr_pkg::PH_IDLE : hcidfr_pkg::PH_PAD;
          end
        end
        hcidfr_pkg::PH_PAD: begin
          phase_next = hcidfr_pkg::PH_IDLE;
        end
        hcidfr_pkg::PH_DRAIN: begin
          remaining_next = rem_m1;
          if (rem_m1 == 16'd0) begin
            phase_next = hcidfr_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_next = hcidfr_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // result decode
  always_comb begin
    res = '0;
    if (frame_start) begin
      if (rx_byte != cfg.reply_code) begin
        res.valid     = 1'b1;
        res.frame_end = 1'b1;
        res.status    = hcidfr_pkg::ST_NO_REPLY;
      end
    end else begin
      case (phase)
        hcidfr_pkg::PH_PRE: begin
          if ((byte_index == 2'd3) && (rem_pre == 16'd0)) begin
            res.valid     = 1'b1;
            res.frame_end = 1'b1;
            res.status    = hcidfr_pkg::ST_NO_MSG;
          end
        end
        hcidfr_pkg::PH_HDR: begin
          if ((byte_index == 2'd3) && !hdr_ok && (rem_m4 == 16'd0)) begin
            res.valid     = 1'b1;
            res.frame_end = 1'b1;
            res.status    = hcidfr_pkg::ST_INVALID;
          end
        end
        hcidfr_pkg::PH_ARGS: begin
          res.valid      = 1'b1;
          res.data_valid = 1'b1;
          res.data_byte  = rx_byte;
          if ((rem_m1 == 16'd0) && length_reg[0]) begin
            res.frame_end = 1'b1;
            res.opcode    = opcode_reg;
            res.length    = length_reg;
          end
        end
        hcidfr_pkg::PH_PAD: begin
          res.valid     = 1'b1;
          res.frame_end = 1'b1;
          res.opcode    = opcode_reg;
          res.length    = length_reg;
        end
        hcidfr_pkg::PH_DRAIN: begin
          if (rem_m1 == 16'd0) begin
            res.valid     = 1'b1;
            res.frame_end = 1'b1;
            res.status    = status_reg;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= hcidfr_pkg::PH_IDLE;
      remaining   <= 16'd0;
      byte_index  <= 2'd0;
      packet_type <= 8'd0;
      opcode_reg  <= 16'd0;
      length_reg  <= 8'd0;
      status_reg  <= hcidfr_pkg::ST_OK;
    end else if (in_fire) begin
      phase       <= phase_next;
      remaining   <= remaining_next;
      byte_index  <= byte_index_next;
      packet_type <= packet_type_next;
      opcode_reg  <= opcode_reg_next;
      length_reg  <= length_reg_next;
      status_reg  <= status_reg_next;
    end
  end

endmodule
`default_nettype wire

[sv/spi_hci_event_deframer_core.sv]
// SPI HCI event deframer: receive side of one HCI read transaction.
// Input channel (in_valid/in_stall) carries one beat per byte returned by the
// slave; frame_start marks the byte answering the read opcode. Output channel
// (out_valid/out_stall) carries one beat per argument byte; frame_end marks
// the last beat of each finished frame, with status (opcode and length if OK).
// The user writes registers reply_code, event_type, data_type, max_len through
// write_enable/reg_index/reg_wdata while the block is idle; it does not check.
// Throughput: one input beat per cycle while in_stall is low; the parser
// decodes each beat combinationally between the input and the output register.
// A result register plus one skid entry sit on the output; when the receiver
// stalls, a result beat fills the skid entry and in_stall rises with it, so
// no beat is lost; in_stall drops once the skid entry has moved out.
// Reset (rst, synchronous) returns the parser to idle, clears both output
// entries and loads the register defaults (2, 4, 2, 255).
`default_nettype none
module spi_hci_event_deframer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        write_enable,
  input  wire logic [1:0]  reg_index,
  input  wire logic [7:0]  reg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        frame_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             data_valid,
  output logic [7:0]       data_byte,
  output logic             frame_end,
  output logic [1:0]       status,
  output logic [15:0]      opcode,
  output logic [7:0]       length
);

  hcidfr_pkg::cfg_t cfg;
  hcidfr_pkg::res_t res;
  hcidfr_pkg::res_t out_reg;
  hcidfr_pkg::res_t skid;
  logic             skid_valid;
  logic             in_fire;
  logic             out_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reply_code <= 8'd2;
      cfg.event_type <= 8'd4;
      cfg.data_type  <= 8'd2;
      cfg.max_len    <= 8'd255;
    end else if (write_enable) begin
      case (reg_index)
        hcidfr_pkg::REG_REPLY_CODE: cfg.reply_code <= reg_wdata;
        hcidfr_pkg::REG_EVENT_TYPE: cfg.event_type <= reg_wdata;
        hcidfr_pkg::REG_DATA_TYPE:  cfg.data_type  <= reg_wdata;
        hcidfr_pkg::REG_MAX_LEN:    cfg.max_len    <= reg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  hcidfr_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire && res.valid;
      end
    end else if (in_fire && res.valid) begin
      // output held: park the new beat
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      out_reg <= skid_valid ? skid : res;
    end
    if (in_fire && res.valid && out_valid && !out_fire) begin
      skid <= res;
    end
  end

  assign data_valid = out_reg.data_valid;
  assign data_byte  = out_reg.data_byte;
  assign frame_end  = out_reg.frame_end;
  assign status     = out_reg.status;
  assign opcode     = out_reg.opcode;
  assign length     = out_reg.length;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a stalled output");

  a_fault_hides_header: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end && (status != hcidfr_pkg::ST_OK)) |->
      ((opcode == 16'd0) && (length == 8'd0) && !data_valid))
    else $error("header fields shown on a faulted frame end");

  a_data_ok_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && data_valid) |-> (status == hcidfr_pkg::ST_OK))
    else $error("argument beat carries a fault status");
`endif

endmodule
`default_nettype wire

[bench/hci_deframer_checker.sv]
// checker for the spi hci event deframer: predicts result beats and compares them
`timescale 1ns / 100ps
module hci_deframer_checker
  import hcidfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        write_enable,
  input  wire logic [1:0]  reg_index,
  input  wire logic [7:0]  reg_wdata,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        frame_start,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        data_valid,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_end,
  input  wire logic [1:0]  status,
  input  wire logic [15:0] opcode,
  input  wire logic [7:0]  length,
  output int               fail_count,
  output int               beats_checked,
  output int               beats_pending
);

  cfg_t        cfg;
  phase_t      ph;
  logic [15:0] left_cnt;
  logic [2:0]  hdr_idx;
  logic [7:0]  pkt_type;
  logic [15:0] op_acc;
  logic [7:0]  arg_len;
  logic [1:0]  frame_status;
  res_t        pending_beats[$];
  int          n_fail;
  int          n_checked;

  assign fail_count    = n_fail;
  assign beats_checked = n_checked;
  assign beats_pending = pending_beats.size();

  initial begin
    n_fail = 0;
    n_checked = 0;
  end

  task automatic queue_beat(input logic dv, input logic [7:0] db, input logic fe,
                            input logic [1:0] st);
    res_t r;
    r.valid      = 1'b1;
    r.data_valid = dv;
    r.data_byte  = db;
    r.frame_end  = fe;
    r.status     = st;
    // opcode and length only show on a clean frame end
    r.opcode     = (fe && st == ST_OK) ? op_acc : 16'h0000;
    r.length     = (fe && st == ST_OK) ? arg_len : 8'h00;
    pending_beats.push_back(r);
    if (fe) ph = PH_IDLE;
  endtask

  task automatic deframe_byte(input logic [7:0] rx, input logic fs);
    if (fs) begin
      hdr_idx = 3'd0;
      left_cnt = 16'h0000;
      pkt_type = 8'h00;
      op_acc = 16'h0000;
      arg_len = 8'h00;
      frame_status = ST_OK;
      if (rx != cfg.reply_code) begin
        frame_status = ST_NO_REPLY;
        queue_beat(1'b0, 8'h00, 1'b1, ST_NO_REPLY);
      end else begin
        ph = PH_PRE;
      end
      return;
    end
    case (ph)
      PH_PRE: begin
        // two ignored bytes, then big-endian payload length
        if (hdr_idx == 3'd2) left_cnt = {rx, 8'h00};
        else if (hdr_idx == 3'd3) left_cnt = left_cnt | {8'h00, rx};
        hdr_idx = hdr_idx + 3'd1;
        if (hdr_idx == 3'd4) begin
          hdr_idx = 3'd0;
          if (left_cnt < 16'd4) begin
            frame_status = ST_NO_MSG;
            if (left_cnt == 16'd0) queue_beat(1'b0, 8'h00, 1'b1, ST_NO_MSG);
            else ph = PH_DRAIN;
          end else begin
            ph = PH_HDR;
          end
        end
      end
      PH_HDR: begin
        if (hdr_idx == 3'd0) pkt_type = rx;
        else if (hdr_idx == 3'd1) op_acc = {8'h00, rx};
        else if (hdr_idx == 3'd2) op_acc[15:8] = rx;
        hdr_idx = hdr_idx + 3'd1;
        if (hdr_idx == 3'd4) begin
          hdr_idx = 3'd0;
          left_cnt = left_cnt - 16'd4;
          if ((pkt_type == cfg.event_type || pkt_type == cfg.data_type) &&
              rx <= cfg.max_len) begin
            arg_len = rx;
            left_cnt = {8'h00, rx};
            ph = (rx == 8'h00) ? PH_PAD : PH_ARGS;
          end else begin
            frame_status = ST_INVALID;
            if (left_cnt == 16'd0) queue_beat(1'b0, 8'h00, 1'b1, ST_INVALID);
            else ph = PH_DRAIN;
          end
        end
      end
      PH_ARGS: begin
        left_cnt = left_cnt - 16'd1;
        // odd length ends on the last argument, even length needs a pad byte
        if (left_cnt == 16'd0 && arg_len[0]) begin
          queue_beat(1'b1, rx, 1'b1, ST_OK);
        end else begin
          if (left_cnt == 16'd0) ph = PH_PAD;
          queue_beat(1'b1, rx, 1'b0, ST_OK);
        end
      end
      PH_PAD: queue_beat(1'b0, 8'h00, 1'b1, ST_OK);
      PH_DRAIN: begin
        left_cnt = left_cnt - 16'd1;
        if (left_cnt == 16'd0) queue_beat(1'b0, 8'h00, 1'b1, frame_status);
      end
      default: ph = PH_IDLE;
    endcase
  endtask

  task automatic cmp_field(input string fname, input logic [15:0] want,
                           input logic [15:0] got, inout bit bad);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, fname, want, got);
      bad = 1'b1;
    end
  endtask

  task automatic check_beat();
    res_t want;
    bit   bad;
    bad = 1'b0;
    if (pending_beats.size() == 0) begin
      $display("%0t ns: result beat with none expected, actual data_byte %0h frame_end %0b",
               $time, data_byte, frame_end);
      n_fail++;
    end else begin
      want = pending_beats.pop_front();
      cmp_field("data_valid", 16'(want.data_valid), 16'(data_valid), bad);
      cmp_field("data_byte", 16'(want.data_byte), 16'(data_byte), bad);
      cmp_field("frame_end", 16'(want.frame_end), 16'(frame_end), bad);
      cmp_field("status", 16'(want.status), 16'(status), bad);
      cmp_field("opcode", want.opcode, opcode, bad);
      cmp_field("length", 16'(want.length), 16'(length), bad);
      if (bad) n_fail++;
      n_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg = {8'd2, 8'd4, 8'd2, 8'd255};
      ph = PH_IDLE;
      left_cnt = 16'h0000;
      hdr_idx = 3'd0;
      pkt_type = 8'h00;
      op_acc = 16'h0000;
      arg_len = 8'h00;
      frame_status = ST_OK;
      pending_beats.delete();
    end else begin
      if (write_enable) begin
        case (reg_index)
          REG_REPLY_CODE: cfg.reply_code = reg_wdata;
          REG_EVENT_TYPE: cfg.event_type = reg_wdata;
          REG_DATA_TYPE:  cfg.data_type = reg_wdata;
          REG_MAX_LEN:    cfg.max_len = reg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) deframe_byte(rx_byte, frame_start);
      if (out_valid && !out_stall) check_beat();
    end
  end

endmodule

[bench/tb_spi_hci_event_deframer_core.sv]
// testbench top for the spi hci event deframer: stimulus, idling and verdict
`timescale 1ns / 100ps
module tb_spi_hci_event_deframer_core;
  import hcidfr_pkg::*;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_BURSTY, STALL_HEAVY} stall_mode_t;

  logic        clk;
  logic        rst;
  logic        write_enable;
  logic [1:0]  reg_index;
  logic [7:0]  reg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        frame_start;
  logic        out_valid;
  logic        out_stall;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic        frame_end;
  logic [1:0]  status;
  logic [15:0] opcode;
  logic [7:0]  length;

  int chk_fail;
  int chk_checked;
  int chk_left;

  logic [8:0] beat_q[$];
  int         n_items;
  int         n_frames;
  int         burst_left;
  int         gap_left;
  logic [7:0] cfg_reply;
  logic [7:0] cfg_event;
  logic [7:0] cfg_data;
  logic [7:0] cfg_max;

  spi_hci_event_deframer_core dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .reg_wdata    (reg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_valid   (data_valid),
    .data_byte    (data_byte),
    .frame_end    (frame_end),
    .status       (status),
    .opcode       (opcode),
    .length       (length)
  );

  hci_deframer_checker chk (
    .clk           (clk),
    .rst           (rst),
    .write_enable  (write_enable),
    .reg_index     (reg_index),
    .reg_wdata     (reg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .frame_start   (frame_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .data_valid    (data_valid),
    .data_byte     (data_byte),
    .frame_end     (frame_end),
    .status        (status),
    .opcode        (opcode),
    .length        (length),
    .fail_count    (chk_fail),
    .beats_checked (chk_checked),
    .beats_pending (chk_left)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // sender: bursts of random length, random gaps, sometimes long unbroken runs
  initial begin : sender
    logic taken;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    frame_start = 1'b0;
    burst_left = 1;
    gap_left = 0;
    forever begin
      @(posedge clk);
      taken = in_valid && !in_stall;
      @(negedge clk);
      if (!rst && (!in_valid || taken)) begin
        if (gap_left > 0 || beat_q.size() == 0) begin
          in_valid = 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          {frame_start, rx_byte} = beat_q.pop_front();
          in_valid = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(30, 80);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 8);
              gap_left = $urandom_range(1, 6);
            end
          end
        end
      end
    end
  end

  // receiver stall pattern, switching among random stall modes
  initial begin : receiver
    stall_mode_t mode;
    int          tick;
    out_stall = 1'b0;
    tick = 0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      repeat ($urandom_range(20, 80)) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:   out_stall = 1'b0;
          STALL_LIGHT:  out_stall = ($urandom_range(0, 9) < 3);
          STALL_BURSTY: out_stall = (tick % 3 == 0);
          STALL_HEAVY:  out_stall = ($urandom_range(0, 9) < 7);
          default:      out_stall = 1'b0;
        endcase
        tick++;
      end
    end
  end

  task automatic push_beat(input logic fs, input logic [7:0] rx);
    beat_q.push_back({fs, rx});
    n_items++;
  endtask

  task automatic add_preamble(input logic [7:0] reply, input logic [15:0] plen);
    push_beat(1'b1, reply);
    push_beat(1'b0, 8'($urandom));
    push_beat(1'b0, 8'($urandom));
    push_beat(1'b0, plen[15:8]);
    push_beat(1'b0, plen[7:0]);
    n_frames++;
  endtask

  task automatic add_packet(input logic [7:0] ptype, input logic [15:0] op,
                            input logic [7:0] alen, input int tail);
    push_beat(1'b0, ptype);
    push_beat(1'b0, op[7:0]);
    push_beat(1'b0, op[15:8]);
    push_beat(1'b0, alen);
    repeat (tail) push_beat(1'b0, 8'($urandom));
  endtask

  // all beats accepted and every result back
  task automatic wait_quiet();
    @(posedge clk);
    while (beat_q.size() != 0 || in_valid) @(posedge clk);
    @(negedge clk);
    while (chk_left != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    write_enable = 1'b1;
    reg_index = idx;
    reg_wdata = val;
    @(negedge clk);
    write_enable = 1'b0;
    case (idx)
      REG_REPLY_CODE: cfg_reply = val;
      REG_EVENT_TYPE: cfg_event = val;
      REG_DATA_TYPE:  cfg_data = val;
      REG_MAX_LEN:    cfg_max = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] reply, input logic [7:0] evt,
                            input logic [7:0] dat, input logic [7:0] maxl);
    wait_quiet();
    write_reg(REG_REPLY_CODE, reply);
    write_reg(REG_EVENT_TYPE, evt);
    write_reg(REG_DATA_TYPE, dat);
    write_reg(REG_MAX_LEN, maxl);
  endtask

  task automatic run_random(input int count);
    int          stop_at;
    int          kind;
    int          k;
    logic [7:0]  ptype;
    logic [7:0]  alen;
    logic [7:0]  cap;
    logic [15:0] op;
    logic [15:0] plen;
    stop_at = n_items + count;
    while (n_items < stop_at) begin
      kind = $urandom_range(0, 99);
      op = 16'($urandom);
      if (kind < 50) begin
        // well-formed event or data packet
        ptype = $urandom_range(0, 1) ? cfg_event : cfg_data;
        cap = (cfg_max < 8'd10) ? cfg_max : 8'd10;
        if ($urandom_range(0, 39) == 0) alen = 8'($urandom_range(0, cfg_max));
        else alen = 8'($urandom_range(0, cap));
        plen = 16'(4 + alen + (alen[0] ? 0 : 1));
        if ($urandom_range(0, 3) == 0) plen = 16'($urandom_range(4, 65535));
        add_preamble(cfg_reply, plen);
        add_packet(ptype, op, alen, alen + (alen[0] ? 0 : 1));
      end else if (kind < 68) begin
        // header rejected by type or by length, rest drained
        plen = 16'($urandom_range(4, 14));
        if (cfg_max != 8'd255 && $urandom_range(0, 1)) begin
          ptype = $urandom_range(0, 1) ? cfg_event : cfg_data;
          alen = 8'($urandom_range(cfg_max + 1, 255));
        end else begin
          ptype = 8'($urandom);
          while (ptype == cfg_event || ptype == cfg_data) ptype = 8'($urandom);
          alen = 8'($urandom);
        end
        add_preamble(cfg_reply, plen);
        add_packet(ptype, op, alen, plen - 4);
      end else if (kind < 78) begin
        plen = 16'($urandom_range(0, 3));
        add_preamble(cfg_reply, plen);
        repeat (plen) push_beat(1'b0, 8'($urandom));
      end else if (kind < 86) begin
        push_beat(1'b1, cfg_reply ^ 8'($urandom_range(1, 255)));
        n_frames++;
      end else if (kind < 94) begin
        // frame cut short, the next frame start abandons it
        add_preamble(cfg_reply, 16'($urandom_range(4, 40)));
        k = $urandom_range(0, 5);
        repeat (k) push_beat(1'b0, 8'($urandom));
      end else begin
        // bytes with no frame start, not counted as stimulus
        k = $urandom_range(1, 3);
        repeat (k) beat_q.push_back({1'b0, 8'($urandom)});
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    write_enable = 1'b0;
    reg_index = REG_REPLY_CODE;
    reg_wdata = 8'h00;
    n_items = 0;
    n_frames = 0;
    cfg_reply = 8'd2;
    cfg_event = 8'd4;
    cfg_data = 8'd2;
    cfg_max = 8'd255;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed frames under reset defaults
    beat_q.push_back({1'b0, 8'hA5});
    push_beat(1'b1, 8'hFF);
    n_frames++;
    add_preamble(8'h02, 16'h0000);
    add_preamble(8'h02, 16'h0005);
    add_packet(8'h02, 16'hFFFF, 8'h00, 1);
    push_beat(1'b1, 8'h02);
    push_beat(1'b0, 8'h00);
    push_beat(1'b0, 8'hFF);
    add_preamble(8'h02, 16'h0004);
    add_packet(8'hFF, 16'h1234, 8'h00, 0);

    run_random(130);
    set_config(8'h00, 8'hFF, 8'h00, 8'h00);
    run_random(130);
    set_config(8'hFF, 8'h80, 8'h7F, 8'hFF);
    run_random(130);
    set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(1, 30)));
    run_random(130);
    wait_quiet();

    $display("sent %0d input beats in %0d frames across four register settings",
             n_items, n_frames);
    $display("checked %0d result beats, %0d mismatching", chk_checked, chk_fail);
    if (chk_fail == 0 && chk_left == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/hcidfr_pkg.sv
sv/hcidfr_parse.sv
sv/spi_hci_event_deframer_core.sv
bench/hci_deframer_checker.sv
bench/tb_spi_hci_event_deframer_core.sv
